@@ src/rmq_pkg.sv @@
// Shared types and constants for the rotation matrix to quaternion block.
`default_nettype none
package rmq_pkg;

  localparam int DW        = 16;           // data width of matrix and quaternion words
  localparam int FB        = 14;           // fraction bits
  localparam int NW        = DW + 1;       // numerator width
  localparam int AW        = DW + 3;       // root argument width, signed
  localparam int RADW      = 32;           // radicand width (argument shifted by FB)
  localparam int RTW       = RADW / 2;     // root width
  localparam int REMW      = RTW + 2;      // root remainder width
  localparam int SQ_STEPS  = RTW;          // one root bit per stage
  localparam int QW        = NW;           // quotient bits produced
  localparam int DVW       = NW + FB;      // dividend width
  localparam int DSW       = RTW + 1;      // divisor width (2r)
  localparam int SETUP_STG = SQ_STEPS;
  localparam int NSTG      = SQ_STEPS + 1 + QW;
  localparam int FIFO_DEPTH = 4;
  localparam int FPW       = $clog2(FIFO_DEPTH);

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_M00   = 2'd1;
  localparam logic [1:0] BR_M11   = 2'd2;
  localparam logic [1:0] BR_M22   = 2'd3;

  // Classified item handed from the front end to the arithmetic back end.
  typedef struct packed {
    logic [1:0]            br;
    logic                  err;
    logic [RADW-1:0]       rad;
    logic [2:0][NW-1:0]    num;   // numerators of the three divided components, index order
  } fe_t;

  // State carried down the back-end pipeline.
  typedef struct packed {
    logic                  vld;
    logic [1:0]            br;
    logic                  err;
    logic [2:0][NW-1:0]    num;
    logic [RADW-1:0]       rad;
    logic [REMW-1:0]       rem;
    logic [RTW-1:0]        root;
    logic [DSW-1:0]        dsr;
    logic [DW-1:0]         sel;
    logic [2:0]            neg;
    logic [2:0]            ovf;
    logic [2:0][NW-1:0]    dvd;   // dividend bits still to bring down
    logic [2:0][DSW-1:0]   prem;  // partial remainder
    logic [2:0][QW-1:0]    quo;
  } stg_t;

endpackage
`default_nettype wire

@@ src/rmq_front.sv @@
// Front end: takes a matrix, picks the branch and forms the root argument and numerators.
`default_nettype none
module rmq_front (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [rmq_pkg::DW-1:0]  in_m00,
  input  wire logic [rmq_pkg::DW-1:0]  in_m01,
  input  wire logic [rmq_pkg::DW-1:0]  in_m02,
  input  wire logic [rmq_pkg::DW-1:0]  in_m10,
  input  wire logic [rmq_pkg::DW-1:0]  in_m11,
  input  wire logic [rmq_pkg::DW-1:0]  in_m12,
  input  wire logic [rmq_pkg::DW-1:0]  in_m20,
  input  wire logic [rmq_pkg::DW-1:0]  in_m21,
  input  wire logic [rmq_pkg::DW-1:0]  in_m22,
  output logic                         push_valid,
  input  wire logic                    push_ready,
  output rmq_pkg::fe_t                 push_data
);

  localparam int AW = rmq_pkg::AW;
  localparam int NW = rmq_pkg::NW;

  logic             vld_r, vld_nxt;
  rmq_pkg::fe_t     ent_r, ent_nxt;
  logic signed [AW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  logic signed [AW-1:0] tr, arg, one;

  assign one = AW'(1) <<< rmq_pkg::FB;

  always_comb begin
    a00 = AW'($signed(in_m00)); a01 = AW'($signed(in_m01)); a02 = AW'($signed(in_m02));
    a10 = AW'($signed(in_m10)); a11 = AW'($signed(in_m11)); a12 = AW'($signed(in_m12));
    a20 = AW'($signed(in_m20)); a21 = AW'($signed(in_m21)); a22 = AW'($signed(in_m22));
    tr  = a00 + a11 + a22;
    ent_nxt = '0;
    if (tr > 0) begin
      ent_nxt.br     = rmq_pkg::BR_TRACE;
      arg            = tr + one;
      ent_nxt.num[0] = NW'(a21 - a12);
      ent_nxt.num[1] = NW'(a02 - a20);
      ent_nxt.num[2] = NW'(a10 - a01);
    end else if (a00 > a11 && a00 > a22) begin
      ent_nxt.br     = rmq_pkg::BR_M00;
      arg            = one + a00 - a11 - a22;
      ent_nxt.num[0] = NW'(a21 - a12);
      ent_nxt.num[1] = NW'(a01 + a10);
      ent_nxt.num[2] = NW'(a02 + a20);
    end else if (a11 > a22) begin
      ent_nxt.br     = rmq_pkg::BR_M11;
      arg            = one + a11 - a00 - a22;
      ent_nxt.num[0] = NW'(a02 - a20);
      ent_nxt.num[1] = NW'(a01 + a10);
      ent_nxt.num[2] = NW'(a12 + a21);
    end else begin
      ent_nxt.br     = rmq_pkg::BR_M22;
      arg            = one + a22 - a00 - a11;
      ent_nxt.num[0] = NW'(a10 - a01);
      ent_nxt.num[1] = NW'(a02 + a20);
      ent_nxt.num[2] = NW'(a12 + a21);
    end
    ent_nxt.err = (arg <= 0);
    // A positive argument stays below 2^17, so the shifted radicand fits.
    ent_nxt.rad = rmq_pkg::RADW'(arg[AW-3:0]) << rmq_pkg::FB;
  end

  assign in_ready   = !vld_r || push_ready;
  assign push_valid = vld_r;
  assign push_data  = ent_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_ready) begin
      vld_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (in_valid && in_ready) begin
      ent_r <= ent_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/rmq_fifo.sv @@
// Short queue of classified items between the front end and the back end.
`default_nettype none
module rmq_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire rmq_pkg::fe_t  push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output rmq_pkg::fe_t       pop_data
);

  localparam int FPW = rmq_pkg::FPW;

  rmq_pkg::fe_t        mem_r [rmq_pkg::FIFO_DEPTH];
  logic [FPW-1:0]      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [FPW:0]        cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign push_ready = (cnt_r != (FPW+1)'(rmq_pkg::FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ src/rmq_back.sv @@
// Back end: pipelined square root, three pipelined dividers and output saturation.
`default_nettype none
module rmq_back (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    pop_valid,
  output logic                         pop_ready,
  input  wire rmq_pkg::fe_t            pop_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [rmq_pkg::DW-1:0]       out_quat_w,
  output logic [rmq_pkg::DW-1:0]       out_quat_x,
  output logic [rmq_pkg::DW-1:0]       out_quat_y,
  output logic [rmq_pkg::DW-1:0]       out_quat_z,
  output logic [1:0]                   out_branch_taken,
  output logic                         out_root_error
);

  localparam int DW   = rmq_pkg::DW;
  localparam int NW   = rmq_pkg::NW;
  localparam int QW   = rmq_pkg::QW;
  localparam int DSW  = rmq_pkg::DSW;
  localparam int DVW  = rmq_pkg::DVW;
  localparam int REMW = rmq_pkg::REMW;
  localparam int RTW  = rmq_pkg::RTW;
  localparam int NSTG = rmq_pkg::NSTG;

  rmq_pkg::stg_t          pipe_r [NSTG];
  rmq_pkg::stg_t          pipe_nxt [NSTG];
  rmq_pkg::stg_t          head;
  logic                   en;
  logic                   ov_r, ov_nxt;
  logic [3:0][DW-1:0]     q_r, q_nxt;
  logic [1:0]             br_r;
  logic                   err_r;
  logic [2:0][DW-1:0]     res;
  logic [REMW+1:0]        rem2;
  logic [REMW+1:0]        trial;
  logic [NW-1:0]          mag;
  logic [DVW-1:0]         dvd_full;
  logic [DSW:0]           p2;
  rmq_pkg::stg_t          cur;

  // The whole pipeline moves whenever the output register is free or being emptied.
  assign en        = !ov_r || out_ready;
  assign pop_ready = en;

  always_comb begin
    head      = '0;
    head.vld  = pop_valid;
    head.br   = pop_data.br;
    head.err  = pop_data.err;
    head.num  = pop_data.num;
    head.rad  = pop_data.rad;
  end

  always_comb begin
    rem2 = '0; trial = '0; mag = '0; dvd_full = '0; p2 = '0; cur = '0;
    for (int k = 0; k < NSTG; k++) begin
      cur = (k == 0) ? head : pipe_r[(k == 0) ? 0 : k - 1];
      pipe_nxt[k] = cur;
      if (k < rmq_pkg::SETUP_STG) begin
        // One result bit of the integer square root per stage.
        rem2  = {cur.rem, cur.rad[rmq_pkg::RADW-1 -: 2]};
        trial = (REMW+2)'({cur.root, 2'b01});
        pipe_nxt[k].rad = cur.rad << 2;
        if (rem2 >= trial) begin
          pipe_nxt[k].rem  = REMW'(rem2 - trial);
          pipe_nxt[k].root = {cur.root[RTW-2:0], 1'b1};
        end else begin
          pipe_nxt[k].rem  = REMW'(rem2);
          pipe_nxt[k].root = {cur.root[RTW-2:0], 1'b0};
        end
      end else if (k == rmq_pkg::SETUP_STG) begin
        // Rounded dividend n*2^FB + r, divisor 2r; the top bits decide overflow at once.
        pipe_nxt[k].dsr = {cur.root, 1'b0};
        pipe_nxt[k].sel = DW'((RTW+1)'(cur.root) + 1'b1 >> 1);
        for (int i = 0; i < 3; i++) begin
          pipe_nxt[k].neg[i] = cur.num[i][NW-1];
          mag      = cur.num[i][NW-1] ? NW'(-cur.num[i]) : cur.num[i];
          dvd_full = (DVW'(mag) << rmq_pkg::FB) + DVW'(cur.root);
          pipe_nxt[k].ovf[i]  = (DSW'(dvd_full[DVW-1:QW]) >= {cur.root, 1'b0});
          pipe_nxt[k].prem[i] = DSW'(dvd_full[DVW-1:QW]);
          pipe_nxt[k].dvd[i]  = dvd_full[QW-1:0];
          pipe_nxt[k].quo[i]  = '0;
        end
      end else begin
        // One quotient bit per stage for each of the three dividers.
        for (int i = 0; i < 3; i++) begin
          p2 = {cur.prem[i], cur.dvd[i][NW-1]};
          pipe_nxt[k].dvd[i] = cur.dvd[i] << 1;
          if (p2 >= (DSW+1)'(cur.dsr)) begin
            pipe_nxt[k].prem[i] = DSW'(p2 - (DSW+1)'(cur.dsr));
            pipe_nxt[k].quo[i]  = {cur.quo[i][QW-2:0], 1'b1};
          end else begin
            pipe_nxt[k].prem[i] = DSW'(p2);
            pipe_nxt[k].quo[i]  = {cur.quo[i][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Saturate and sign the quotients, order the words by branch, zero them on error.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pipe_r[NSTG-1].neg[i]) begin
        if (pipe_r[NSTG-1].ovf[i] || pipe_r[NSTG-1].quo[i] > QW'(1 << (DW-1))) begin
          res[i] = {1'b1, {(DW-1){1'b0}}};
        end else begin
          res[i] = DW'(-pipe_r[NSTG-1].quo[i]);
        end
      end else begin
        if (pipe_r[NSTG-1].ovf[i] || pipe_r[NSTG-1].quo[i] > QW'((1 << (DW-1)) - 1)) begin
          res[i] = {1'b0, {(DW-1){1'b1}}};
        end else begin
          res[i] = DW'(pipe_r[NSTG-1].quo[i]);
        end
      end
    end
    case (pipe_r[NSTG-1].br)
      rmq_pkg::BR_TRACE: q_nxt = {res[2], res[1], res[0], pipe_r[NSTG-1].sel};
      rmq_pkg::BR_M00:   q_nxt = {res[2], res[1], pipe_r[NSTG-1].sel, res[0]};
      rmq_pkg::BR_M11:   q_nxt = {res[2], pipe_r[NSTG-1].sel, res[1], res[0]};
      rmq_pkg::BR_M22:   q_nxt = {pipe_r[NSTG-1].sel, res[2], res[1], res[0]};
      default:           q_nxt = '0;
    endcase
    if (pipe_r[NSTG-1].err) begin
      q_nxt = '0;
    end
    ov_nxt = en ? pipe_r[NSTG-1].vld : ov_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      for (int k = 0; k < NSTG; k++) begin
        pipe_r[k].vld <= 1'b0;
      end
    end else begin
      ov_r <= ov_nxt;
      if (en) begin
        for (int k = 0; k < NSTG; k++) begin
          pipe_r[k].vld <= pipe_nxt[k].vld;
        end
      end
    end
    if (en) begin
      for (int k = 0; k < NSTG; k++) begin
        pipe_r[k].br   <= pipe_nxt[k].br;
        pipe_r[k].err  <= pipe_nxt[k].err;
        pipe_r[k].num  <= pipe_nxt[k].num;
        pipe_r[k].rad  <= pipe_nxt[k].rad;
        pipe_r[k].rem  <= pipe_nxt[k].rem;
        pipe_r[k].root <= pipe_nxt[k].root;
        pipe_r[k].dsr  <= pipe_nxt[k].dsr;
        pipe_r[k].sel  <= pipe_nxt[k].sel;
        pipe_r[k].neg  <= pipe_nxt[k].neg;
        pipe_r[k].ovf  <= pipe_nxt[k].ovf;
        pipe_r[k].dvd  <= pipe_nxt[k].dvd;
        pipe_r[k].prem <= pipe_nxt[k].prem;
        pipe_r[k].quo  <= pipe_nxt[k].quo;
      end
      q_r   <= q_nxt;
      br_r  <= pipe_r[NSTG-1].br;
      err_r <= pipe_r[NSTG-1].err;
    end
  end

  assign out_valid        = ov_r;
  assign out_quat_w       = q_r[0];
  assign out_quat_x       = q_r[1];
  assign out_quat_y       = q_r[2];
  assign out_quat_z       = q_r[3];
  assign out_branch_taken = br_r;
  assign out_root_error   = err_r;

endmodule
`default_nettype wire

@@ src/rotation_matrix_to_quaternion.sv @@
// Top level: rotation matrix to quaternion converter (Shepperd's method, Q2.14).
//
//   Channel  | Handshake            | Payload
//   in_      | in_valid / in_ready  | in_m00 .. in_m22, signed Q2.14
//   out_     | out_valid/out_ready  | out_quat_w/x/y/z, out_branch_taken, out_root_error
//
// One matrix is accepted per cycle until an output stall fills the queue; a matrix passes
// one front-end register, one queue slot, sixteen square-root stages, one divider set-up
// stage, seventeen quotient stages and the output register.
// Reset is synchronous and clears only valid state, queue pointers and the queue count.
// A stall at the output freezes the back-end pipeline; the four-entry queue and the
// front register keep accepting transfers until they fill.
`default_nettype none
module rotation_matrix_to_quaternion (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [rmq_pkg::DW-1:0]  in_m00,
  input  wire logic [rmq_pkg::DW-1:0]  in_m01,
  input  wire logic [rmq_pkg::DW-1:0]  in_m02,
  input  wire logic [rmq_pkg::DW-1:0]  in_m10,
  input  wire logic [rmq_pkg::DW-1:0]  in_m11,
  input  wire logic [rmq_pkg::DW-1:0]  in_m12,
  input  wire logic [rmq_pkg::DW-1:0]  in_m20,
  input  wire logic [rmq_pkg::DW-1:0]  in_m21,
  input  wire logic [rmq_pkg::DW-1:0]  in_m22,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [rmq_pkg::DW-1:0]       out_quat_w,
  output logic [rmq_pkg::DW-1:0]       out_quat_x,
  output logic [rmq_pkg::DW-1:0]       out_quat_y,
  output logic [rmq_pkg::DW-1:0]       out_quat_z,
  output logic [1:0]                   out_branch_taken,
  output logic                         out_root_error
);

  logic          push_valid, push_ready, pop_valid, pop_ready;
  rmq_pkg::fe_t  push_data, pop_data;

  rmq_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_m00(in_m00), .in_m01(in_m01), .in_m02(in_m02),
    .in_m10(in_m10), .in_m11(in_m11), .in_m12(in_m12),
    .in_m20(in_m20), .in_m21(in_m21), .in_m22(in_m22),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
  );

  rmq_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
  );

  rmq_back u_back (
    .clk(clk), .rst_n(rst_n),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_quat_w(out_quat_w), .out_quat_x(out_quat_x),
    .out_quat_y(out_quat_y), .out_quat_z(out_quat_z),
    .out_branch_taken(out_branch_taken), .out_root_error(out_root_error)
  );

endmodule
`default_nettype wire

@@ bench/rotation_matrix_to_quaternion_test.sv @@
// Self-checking testbench for the rotation matrix to quaternion converter.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_test;
  import rmq_pkg::*;

  typedef logic signed [DW-1:0] word_t;

  typedef struct packed {
    word_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } matrix_t;

  typedef struct packed {
    word_t      w, x, y, z;
    logic [1:0] br;
    logic       err;
  } quat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  word_t in_m00 = '0, in_m01 = '0, in_m02 = '0, in_m10 = '0, in_m11 = '0;
  word_t in_m12 = '0, in_m20 = '0, in_m21 = '0, in_m22 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DW-1:0] out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  logic [1:0] out_branch_taken;
  logic out_root_error;

  matrix_t pending_matrices[$];
  quat_t   expected_quats[$];
  int      mismatches = 0;
  int      quats_seen = 0;
  int      branch_hits[4] = '{0, 0, 0, 0};
  int      error_hits = 0;
  bit      stimulus_done = 1'b0;
  bit      idle_free = 1'b0;
  int      hold_off = 0;
  bit      hold_done = 1'b0;
  bit      in_taken = 1'b0;

  rotation_matrix_to_quaternion dut (.*);

  always #5 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned a);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > a) bitv >>= 2;
    while (bitv != 0) begin
      if (a >= res + bitv) begin
        a -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Numerator over 2r, rounded to nearest with ties away from zero, saturated.
  function automatic word_t scaled_quotient(longint n, longint unsigned r);
    longint unsigned mag, q;
    mag = (n < 0) ? longint'(-n) : longint'(n);
    q = ((mag << FB) + r) / (2 * r);
    if (n < 0) return (q > (64'd1 << (DW - 1))) ? word_t'(-(1 << (DW - 1))) : word_t'(-q);
    return (q > ((64'd1 << (DW - 1)) - 1)) ? word_t'((1 << (DW - 1)) - 1) : word_t'(q);
  endfunction

  function automatic quat_t shepperd_quat(matrix_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, arg;
    longint n[4];
    longint unsigned r, half;
    word_t comp[4];
    quat_t res;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    tr = a00 + a11 + a22;
    n = '{0, 0, 0, 0};
    if (tr > 0) begin
      res.br = BR_TRACE; arg = tr + (1 << FB);
      n[1] = a21 - a12; n[2] = a02 - a20; n[3] = a10 - a01;
    end else if (a00 > a11 && a00 > a22) begin
      res.br = BR_M00; arg = (1 << FB) + a00 - a11 - a22;
      n[0] = a21 - a12; n[2] = a01 + a10; n[3] = a02 + a20;
    end else if (a11 > a22) begin
      res.br = BR_M11; arg = (1 << FB) + a11 - a00 - a22;
      n[0] = a02 - a20; n[1] = a01 + a10; n[3] = a12 + a21;
    end else begin
      res.br = BR_M22; arg = (1 << FB) + a22 - a00 - a11;
      n[0] = a10 - a01; n[1] = a02 + a20; n[2] = a12 + a21;
    end
    comp = '{0, 0, 0, 0};
    res.err = (arg <= 0);
    if (!res.err) begin
      r = int_sqrt(longint'(arg) << FB);
      for (int k = 0; k < 4; k++) begin
        if (k == res.br) begin
          half = (r + 1) >> 1;
          comp[k] = (half > (1 << (DW - 1)) - 1) ? word_t'((1 << (DW - 1)) - 1) : word_t'(half);
        end else begin
          comp[k] = scaled_quotient(n[k], r);
        end
      end
    end
    res.w = comp[0]; res.x = comp[1]; res.y = comp[2]; res.z = comp[3];
    return res;
  endfunction

  function automatic word_t rand_word();
    return word_t'($urandom_range(65535));
  endfunction

  // Near-rotation matrix built from a random unit-ish quaternion, with optional noise.
  function automatic matrix_t near_rotation(bit noisy);
    real qw, qx, qy, qz, nrm;
    real e[9];
    matrix_t m;
    qw = $urandom_range(2000) - 1000.0; qx = $urandom_range(2000) - 1000.0;
    qy = $urandom_range(2000) - 1000.0; qz = $urandom_range(2000) - 1000.0;
    nrm = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz) + 1.0e-9;
    qw /= nrm; qx /= nrm; qy /= nrm; qz /= nrm;
    e[0] = 1 - 2 * (qy * qy + qz * qz); e[1] = 2 * (qx * qy - qz * qw);
    e[2] = 2 * (qx * qz + qy * qw);     e[3] = 2 * (qx * qy + qz * qw);
    e[4] = 1 - 2 * (qx * qx + qz * qz); e[5] = 2 * (qy * qz - qx * qw);
    e[6] = 2 * (qx * qz - qy * qw);     e[7] = 2 * (qy * qz + qx * qw);
    e[8] = 1 - 2 * (qx * qx + qy * qy);
    for (int k = 0; k < 9; k++) begin
      int v;
      v = $rtoi(e[k] * 16384.0);
      if (noisy) v += int'($urandom_range(64)) - 32;
      m[(8 - k) * DW +: DW] = word_t'(v);
    end
    return m;
  endfunction

  function automatic matrix_t diag_matrix(word_t d0, word_t d1, word_t d2, word_t off);
    matrix_t m;
    m = '{off, off, off, off, off, off, off, off, off};
    m.m00 = d0; m.m11 = d1; m.m22 = d2;
    return m;
  endfunction

  initial begin
    matrix_t m;
    pending_matrices.push_back(diag_matrix(16384, 16384, 16384, 0));
    pending_matrices.push_back(diag_matrix(16384, -16384, -16384, 0));
    pending_matrices.push_back(diag_matrix(-16384, 16384, -16384, 0));
    pending_matrices.push_back(diag_matrix(-16384, -16384, 16384, 0));
    // Ties on the diagonal must fall to the later branch.
    pending_matrices.push_back(diag_matrix(-100, -100, -200, 50));
    pending_matrices.push_back(diag_matrix(-100, -200, -100, 50));
    pending_matrices.push_back(diag_matrix(-100, -100, -100, 50));
    pending_matrices.push_back(diag_matrix(0, 0, 0, 0));
    // Extreme diagonals; a non-positive root argument would give zero components.
    pending_matrices.push_back(diag_matrix(-32768, -32768, -32768, 0));
    pending_matrices.push_back(diag_matrix(-20000, 32767, 32767, 0));
    pending_matrices.push_back(diag_matrix(-16384, -16384, -16384, 0));
    // Saturating outputs and extreme operands.
    pending_matrices.push_back(diag_matrix(32767, 32767, 32767, 0));
    pending_matrices.push_back(diag_matrix(32767, 32767, 32767, -32768));
    pending_matrices.push_back(diag_matrix(-32768, -32768, -32768, 32767));
    pending_matrices.push_back(diag_matrix(1, -1, -1, 32767));
    pending_matrices.push_back(diag_matrix(-16384, -16384, -16384, -32768));
    m = diag_matrix(-16000, -16000, -16000, 0);
    m.m21 = 32767; m.m12 = -32768; m.m02 = -32768; m.m20 = 32767; m.m10 = 32767;
    pending_matrices.push_back(m);
    m.m00 = 16384; m.m11 = -16384; m.m22 = -16384;
    pending_matrices.push_back(m);
    pending_matrices.push_back('1);
    for (int i = 0; i < 1050; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: m = near_rotation(1'b0);
        5, 6:          m = near_rotation(1'b1);
        default: m = '{rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                       rand_word(), rand_word(), rand_word(), rand_word()};
      endcase
      pending_matrices.push_back(m);
    end
    stimulus_done = 1'b1;
  end

  // Input transfers are recorded at the rising edge where they happen.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_quats.push_back(shepperd_quat({in_m00, in_m01, in_m02, in_m10, in_m11,
                                              in_m12, in_m20, in_m21, in_m22}));
    end
    in_taken <= rst_n && in_valid && in_ready;
  end

  // Driver: one matrix offered at a time, changed only at the falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_matrices.size() > 0 && (idle_free || $urandom_range(99) >= 36)) begin
          matrix_t m;
          m = pending_matrices.pop_front();
          {in_m00, in_m01, in_m02, in_m10, in_m11, in_m12, in_m20, in_m21, in_m22} <= m;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness, with one long hold-off to fill the pipeline.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (quats_seen >= 200 && !idle_free && !hold_done) begin
      hold_off <= 120;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= idle_free || ($urandom_range(99) >= 36);
    end
  end

  // Monitor: compare each transfer with the oldest expected quaternion.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      quat_t got, exp_q;
      got = '{out_quat_w, out_quat_x, out_quat_y, out_quat_z, out_branch_taken, out_root_error};
      quats_seen <= quats_seen + 1;
      // The pipeline is registered from input to output, so an empty queue here means
      // the block produced a result that was never asked for.
      if (expected_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected quaternion %p", got);
      end else begin
        exp_q = expected_quats.pop_front();
        branch_hits[exp_q.br]++;
        if (exp_q.err) error_hits++;
        if (got !== exp_q) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", exp_q, got);
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (300) @(posedge clk);
    idle_free = 1'b1;
    repeat (400) @(posedge clk);
    idle_free = 1'b0;
    wait (stimulus_done && pending_matrices.size() == 0 && !in_valid);
    wait (expected_quats.size() == 0);
    repeat (60) @(posedge clk);
    $display("Checked %0d quaternions: %0d/%0d/%0d/%0d per branch, %0d root errors.",
             quats_seen, branch_hits[0], branch_hits[1], branch_hits[2], branch_hits[3],
             error_hits);
    if (mismatches == 0 && expected_quats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out");
    $display("Verification failed");
    $finish;
  end

endmodule
